// File: hw/rtl/ipv4dq_pkg.sv
package ipv4dq_pkg;

    localparam logic [7:0]  CH_NUL  = 8'h00;
    localparam logic [7:0]  CH_ZERO = 8'h30;
    localparam logic [7:0]  CH_NINE = 8'h39;
    localparam logic [7:0]  CH_DOT  = 8'h2E;
    localparam logic [11:0] OCT_MAX = 12'd255;
    localparam logic [1:0]  DIG_MAX = 2'd3;
    localparam logic [1:0]  LAST_PART = 2'd3;
    localparam logic [3:0]  RADIX   = 4'd10;
    localparam int          NUM_DONE = 3;

    typedef struct packed {
        logic [1:0]                    part_index;
        logic [1:0]                    digit_count;
        logic [7:0]                    running_value;
        logic [NUM_DONE-1:0][7:0]      done_octets;
        logic                          failed_flag;
    } t_parse_state;

    localparam t_parse_state STATE_CLEAR = '0;

endpackage

// File: hw/rtl/ipv4_dotted_quad_parser_core.sv
// An accepted character lands in the input register, and the result of a NUL terminator
// is written from there to the output register once the terminator can advance.
// Throughput: one character per cycle; the parse state is updated in a single pass.
// The input stalls only while a terminator waits behind a stalled result.
// Reset (synchronous, active low) clears the parse state and both valid flags.
module ipv4_dotted_quad_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_parse_ok,
    output logic [31:0] o_ip_address
);

    logic                     r_in_valid;
    logic [7:0]               r_char;
    ipv4dq_pkg::t_parse_state r_state;
    ipv4dq_pkg::t_parse_state n_state;
    logic                     r_out_valid;
    logic                     r_parse_ok;
    logic [31:0]              r_ip_address;
    logic                     n_parse_ok;
    logic [31:0]              n_ip_address;

    logic        advance;
    logic        is_term;
    logic [11:0] next_value;

    assign is_term = (r_char == ipv4dq_pkg::CH_NUL);
    // A terminator needs the output register to be free or draining.
    assign advance = r_in_valid && (!is_term || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    assign next_value = (12'(r_state.running_value) * 12'(ipv4dq_pkg::RADIX))
                      + 12'(r_char - ipv4dq_pkg::CH_ZERO);

    always_comb begin
        n_state      = r_state;
        n_parse_ok   = 1'b0;
        n_ip_address = '0;
        if (is_term) begin
            n_parse_ok = !r_state.failed_flag
                      && (r_state.part_index == ipv4dq_pkg::LAST_PART)
                      && (r_state.digit_count != 2'd0);
            if (n_parse_ok) begin
                n_ip_address = {r_state.done_octets[0], r_state.done_octets[1],
                                r_state.done_octets[2], r_state.running_value};
            end
            n_state = ipv4dq_pkg::STATE_CLEAR;
        end else if (!r_state.failed_flag) begin
            if (r_char >= ipv4dq_pkg::CH_ZERO && r_char <= ipv4dq_pkg::CH_NINE) begin
                if (r_state.digit_count >= ipv4dq_pkg::DIG_MAX
                    || next_value > ipv4dq_pkg::OCT_MAX) begin
                    n_state.failed_flag = 1'b1;
                end else begin
                    n_state.running_value = next_value[7:0];
                    n_state.digit_count   = r_state.digit_count + 2'd1;
                end
            end else if (r_char == ipv4dq_pkg::CH_DOT) begin
                if (r_state.digit_count == 2'd0
                    || r_state.part_index >= ipv4dq_pkg::LAST_PART) begin
                    n_state.failed_flag = 1'b1;
                end else begin
                    for (int k = 0; k < ipv4dq_pkg::NUM_DONE; k++) begin
                        if (r_state.part_index == 2'(k)) begin
                            n_state.done_octets[k] = r_state.running_value;
                        end
                    end
                    n_state.part_index    = r_state.part_index + 2'd1;
                    n_state.digit_count   = 2'd0;
                    n_state.running_value = 8'd0;
                end
            end else begin
                n_state.failed_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= ipv4dq_pkg::STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && is_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_char <= i_char_in;
        end
        if (advance && is_term) begin
            r_parse_ok   <= n_parse_ok;
            r_ip_address <= n_ip_address;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_parse_ok   = r_parse_ok;
    assign o_ip_address = r_ip_address;

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_parse_ok) |-> (o_ip_address == 32'd0))
        else $error("failed parse shows a nonzero address");

    a_clear_after_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_term) |=> (r_state == ipv4dq_pkg::STATE_CLEAR && o_valid))
        else $error("state not cleared or result missing after terminator");

    a_failed_swallows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_term && r_state.failed_flag) |=> $stable(r_state))
        else $error("character changed state after a fault");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && is_term && r_out_valid && i_stall))
        else $error("input stalled without a blocked terminator");

endmodule
